[rtl/kvi_pkg.sv]
package kvi_pkg;

    // Field types
    typedef logic signed [15:0] frame_t;
    typedef logic        [15:0] alpha_t;

    // One keyframe as stored in the table
    typedef struct packed {
        frame_t frame;
        alpha_t alpha;
    } entry_t;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Q1.15 unity
    localparam alpha_t ALPHA_ONE = 16'h8000;

    // Value of a slot that was never written
    localparam entry_t RESET_ENTRY = '{frame: 16'sd1, alpha: ALPHA_ONE};

endpackage

[rtl/kvi_item_if.sv]
interface kvi_item_if;
    import kvi_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    logic   [3:0] slot;
    frame_t frame_number;
    alpha_t key_alpha;

    modport source (output valid, op, slot, frame_number, key_alpha, input ready);
    modport sink   (input valid, op, slot, frame_number, key_alpha, output ready);

endinterface

[rtl/kvi_result_if.sv]
interface kvi_result_if;
    import kvi_pkg::*;

    logic   valid;
    logic   ready;
    alpha_t alpha;

    modport source (output valid, alpha, input ready);
    modport sink   (input valid, alpha, output ready);

endinterface

[rtl/keyframe_visibility_interpolator_unit.sv]
// Keyframe write: no result; the next beat may follow at once.
// Query: an empty table answers 1.0 with no table read; one key or a frame at or before the
// first key is answered from the first key read, a frame at or after the last key from the
// last key read; interpolation takes one table read per key searched, a multiply and a restoring divider.
// A result still waiting on the output holds the next answer back; one query at a time.
// Reset (rst_n low, async): key count 0, every slot reads as frame 1, alpha 1.0.
module keyframe_visibility_interpolator_unit #(
    parameter int MAX_KEYFRAMES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    kvi_item_if.sink           item,
    kvi_result_if.source       result
);
    import kvi_pkg::*;

    localparam int AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int CW = $clog2(MAX_KEYFRAMES + 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_FIRST  = 10'b0000000010,
        ST_LAST   = 10'b0000000100,
        ST_SCAN   = 10'b0000001000,
        ST_SETUP  = 10'b0000010000,
        ST_MUL    = 10'b0000100000,
        ST_LOAD   = 10'b0001000000,
        ST_DIV    = 10'b0010000000,
        ST_ADJ    = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } state_t;

    // Key table and per-slot written flags
    entry_t                 mem [MAX_KEYFRAMES];
    logic [MAX_KEYFRAMES-1:0] valid_reg;
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    entry_t                 wr_entry;
    entry_t                 rd_entry;

    logic [4:0]             count_reg;
    state_t                 state_reg, state_next;
    frame_t                 qframe_reg, qframe_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [CW-1:0]          idx_reg, idx_next;
    entry_t                 prev_reg, prev_next;
    entry_t                 next_reg, next_next;
    entry_t                 last_reg, last_next;
    logic signed [16:0]     a_diff_reg, a_diff_next;
    logic signed [16:0]     f_diff_reg, f_diff_next;
    logic [15:0]            den_reg, den_next;
    logic signed [33:0]     prod_reg, prod_next;
    logic [31:0]            dvd_reg, dvd_next;
    logic [15:0]            rem_reg, rem_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    alpha_t                 res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    alpha_t                 out_alpha_reg, out_alpha_next;

    logic                   accept;
    logic [CW-1:0]          n_eff;
    logic signed [16:0]     df, den;
    logic [33:0]            mag;
    logic [16:0]            rem_sh;
    logic [16:0]            rem_sub;
    logic signed [33:0]     sum;

    assign item.ready   = (state_reg == ST_IDLE);
    assign accept       = item.valid && item.ready;
    assign result.valid = out_valid_reg;
    assign result.alpha = out_alpha_reg;

    // Count clamped to table depth
    always_comb
    begin
        if (int'(count_reg) > MAX_KEYFRAMES)
            n_eff = CW'(MAX_KEYFRAMES);
        else
            n_eff = CW'(count_reg);
    end

    // Keyframe write on accept, alpha saturated to 1.0
    assign wr_en          = accept && (item.op == OP_WRITE) && (int'(item.slot) < MAX_KEYFRAMES);
    assign wr_addr        = AW'(item.slot);
    assign wr_entry.frame = item.frame_number;
    assign wr_entry.alpha = (item.key_alpha > ALPHA_ONE) ? ALPHA_ONE : item.key_alpha;

    // Unwritten slots read as the reset keyframe
    assign rd_entry = rd_valid_reg ? rd_data_reg : RESET_ENTRY;

    // Table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_entry;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_wr_en)
            count_reg <= cfg_wr_data;
    end

    // Divider datapath: one quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // Frame deltas against the lower key
    assign df  = $signed({qframe_reg[15], qframe_reg}) - $signed({prev_reg.frame[15], prev_reg.frame});
    assign den = $signed({next_reg.frame[15], next_reg.frame})
               - $signed({prev_reg.frame[15], prev_reg.frame});
    assign mag = prod_reg[33] ? 34'(-prod_reg) : 34'(prod_reg);
    assign sum = $signed({18'd0, prev_reg.alpha})
               + (neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg}));

    // Sequencer and read address
    always_comb
    begin
        state_next     = state_reg;
        qframe_next    = qframe_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        next_next      = next_reg;
        last_next      = last_reg;
        a_diff_next    = a_diff_reg;
        f_diff_next    = f_diff_reg;
        den_next       = den_reg;
        prod_next      = prod_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_alpha_next = out_alpha_reg;
        rd_addr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.op == OP_QUERY)
                begin
                    qframe_next = item.frame_number;
                    n_next      = n_eff;
                    if (n_eff == '0)
                    begin
                        res_next   = ALPHA_ONE;
                        state_next = ST_FINISH;
                    end
                    else
                        state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                prev_next = rd_entry;
                rd_addr   = AW'(n_reg - 1'b1);
                if (n_reg == CW'(1) || qframe_reg <= rd_entry.frame)
                begin
                    res_next   = rd_entry.alpha;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                last_next = rd_entry;
                rd_addr   = AW'(1);
                if (qframe_reg >= rd_entry.frame)
                begin
                    res_next   = rd_entry.alpha;
                    state_next = ST_FINISH;
                end
                else if (n_reg == CW'(2))
                begin
                    next_next  = rd_entry;
                    state_next = ST_SETUP;
                end
                else
                begin
                    idx_next   = CW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_addr = AW'(idx_reg + 1'b1);
                if (rd_entry.frame > qframe_reg)
                begin
                    next_next  = rd_entry;
                    state_next = ST_SETUP;
                end
                else
                begin
                    prev_next = rd_entry;
                    if (CW'(idx_reg + 1'b1) == CW'(n_reg - 1'b1))
                    begin
                        next_next  = last_reg;
                        state_next = ST_SETUP;
                    end
                    else
                        idx_next = CW'(idx_reg + 1'b1);
                end
            end
            ST_SETUP:
            begin
                if (df == 17'sd0 || den <= 17'sd0)
                begin
                    res_next   = prev_reg.alpha;
                    state_next = ST_FINISH;
                end
                else
                begin
                    a_diff_next = $signed({1'b0, next_reg.alpha}) - $signed({1'b0, prev_reg.alpha});
                    f_diff_next = df;
                    den_next    = den[15:0];
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = a_diff_reg * f_diff_reg;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                neg_next   = prod_reg[33];
                dvd_next   = mag[31:0];
                rem_next   = '0;
                cnt_next   = 5'd31;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!rem_sub[16])
                begin
                    rem_next = rem_sub[15:0];
                    dvd_next = {dvd_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[15:0];
                    dvd_next = {dvd_reg[30:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = ST_ADJ;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_ADJ:
            begin
                if (sum < 34'sd0)
                    res_next = '0;
                else if (sum > $signed({18'd0, ALPHA_ONE}))
                    res_next = ALPHA_ONE;
                else
                    res_next = sum[15:0];
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_alpha_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        qframe_reg    <= qframe_next;
        prev_reg      <= prev_next;
        next_reg      <= next_next;
        last_reg      <= last_next;
        a_diff_reg    <= a_diff_next;
        f_diff_reg    <= f_diff_next;
        den_reg       <= den_next;
        prod_reg      <= prod_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        res_reg       <= res_next;
        out_alpha_reg <= out_alpha_next;
    end

    // Checks
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.alpha <= ALPHA_ONE)
        else $error("alpha above 1.0");

    a_empty_table: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == OP_QUERY && n_eff == '0)
        |=> (state_reg == ST_FINISH && res_reg == ALPHA_ONE))
        else $error("empty table did not answer 1.0");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> state_reg == ST_ADJ)
        else $error("divider overran");

    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (idx_reg >= CW'(1) && idx_reg < CW'(n_reg - 1'b1)))
        else $error("scan index out of range");

endmodule

[tb/tb_top.sv]
module tb_top;
    import kvi_pkg::*;

    localparam int KEY_SLOTS = 16;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [4:0] cfg_wr_data;

    kvi_item_if   item_bus ();
    kvi_result_if result_bus ();

    keyframe_visibility_interpolator_unit #(
        .MAX_KEYFRAMES(KEY_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_bus),
        .result      (result_bus)
    );

    // Shadow copy of the keyframe table and the key count
    frame_t     kf_frame [KEY_SLOTS];
    alpha_t     kf_alpha [KEY_SLOTS];
    logic [4:0] key_count;

    // Alphas owed by the block, oldest first
    alpha_t     alpha_due [$];

    bit         idle_en;
    int         error_count;
    int         write_beats;
    int         query_beats;
    int         lerp_queries;
    int         result_beats;
    int         count_settings;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #6000000;
        $display("keyframe_visibility_interpolator_unit test failed");
        $finish;
    end

    // Expected alpha for a query at frame f against the shadow table
    function automatic alpha_t predict_visibility(input frame_t f);
        int     n;
        int     i;
        longint num;
        longint den;
        longint q;
        n = (key_count > KEY_SLOTS) ? KEY_SLOTS : int'(key_count);
        if (n == 0)
            return ALPHA_ONE;
        if (n == 1 || f <= kf_frame[0])
            return kf_alpha[0];
        if (f >= kf_frame[n-1])
            return kf_alpha[n-1];
        // first key past the frame, stopping at the last one in use
        i = 1;
        while (i < n - 1 && kf_frame[i] <= f)
            i++;
        if (f == kf_frame[i-1] || kf_frame[i] == kf_frame[i-1])
            return kf_alpha[i-1];
        den = longint'(kf_frame[i]) - longint'(kf_frame[i-1]);
        if (den <= 0)
            return kf_alpha[i-1];
        lerp_queries++;
        num = (longint'(kf_alpha[i]) - longint'(kf_alpha[i-1])) *
              (longint'(f) - longint'(kf_frame[i-1]));
        q = num / den + longint'(kf_alpha[i-1]);
        if (q < 0)
            q = 0;
        if (q > longint'(ALPHA_ONE))
            q = longint'(ALPHA_ONE);
        return alpha_t'(q);
    endfunction

    // Random alpha with weight on the ends and on out-of-range values
    function automatic alpha_t random_alpha();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return ALPHA_ONE;
        if (r == 2)
            return alpha_t'($urandom_range(32769, 65535));
        return alpha_t'($urandom_range(0, 32768));
    endfunction

    // Send one item beat and update the shadow state when it is taken
    task automatic send_beat(input logic op, input logic [3:0] slot,
                             input frame_t f, input alpha_t a);
        int gap;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            item_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus.valid        = 1'b1;
        item_bus.op           = op;
        item_bus.slot         = slot;
        item_bus.frame_number = f;
        item_bus.key_alpha    = a;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        if (op == OP_WRITE)
        begin
            kf_frame[slot] = f;
            kf_alpha[slot] = (a > ALPHA_ONE) ? ALPHA_ONE : a;
            write_beats++;
        end
        else
        begin
            alpha_due = {alpha_due, predict_visibility(f)};
            query_beats++;
        end
    endtask

    task automatic write_key(input logic [3:0] slot, input int f, input alpha_t a);
        send_beat(OP_WRITE, slot, frame_t'(f), a);
    endtask

    task automatic query_at(input int f);
        send_beat(OP_QUERY, 4'($urandom_range(0, 15)), frame_t'(f), random_alpha());
    endtask

    // Hold the sender until every owed alpha is back, then let writes settle
    task automatic drain_results();
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (alpha_due.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Key count register, written only with the block idle
    task automatic set_key_count(input logic [4:0] v);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        key_count   = v;
        count_settings++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        alpha_t want;
        if (result_bus.valid && result_bus.ready)
        begin
            if (alpha_due.size() == 0)
            begin
                $error("alpha: unexpected result beat, actual %0d", result_bus.alpha);
                error_count++;
            end
            else
            begin
                want = alpha_due.pop_front();
                result_beats++;
                if (result_bus.alpha !== want)
                begin
                    $error("alpha mismatch: expected %0d, actual %0d", want,
                           result_bus.alpha);
                    error_count++;
                end
            end
        end
    end

    // Result backpressure in short random bursts
    initial
    begin
        int burst;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 3);
                result_bus.ready = 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                result_bus.ready = 1'b1;
        end
    end

    // Empty table and never-written slots after reset
    task automatic test_reset_table();
        query_at(-32768);
        query_at(0);
        query_at(32767);
        set_key_count(5'd1);
        query_at(0);
        set_key_count(5'd2);
        query_at(5);
    endtask

    // Hand-built table: duplicates, falling alpha, saturation, unsorted tail
    task automatic test_directed_keys();
        write_key(4'd0, -32768, 16'd0);
        write_key(4'd1, -100, 16'd16384);
        write_key(4'd2, -100, 16'd1000);
        write_key(4'd3, 200, 16'd500);
        write_key(4'd4, 32767, 16'hFFFF);
        write_key(4'd15, 5, 16'h8001);
        set_key_count(5'd5);
        query_at(-32768);
        query_at(-101);
        query_at(-100);
        query_at(0);
        query_at(199);
        query_at(200);
        query_at(30000);
        query_at(32767);
        // full table: reset slots make the tail unsorted
        set_key_count(5'd16);
        query_at(3);
        query_at(10);
        // counts past the table size act as a full table
        set_key_count(5'd17);
        query_at(3);
        set_key_count(5'd31);
        query_at(4);
    endtask

    // Random tables, mostly sorted, then queries around their span
    task automatic test_random_tables(input int phases);
        int vals [KEY_SLOTS];
        int n;
        int eff;
        int shape;
        int lo;
        int hi;
        int ctr;
        int span;
        int qlo;
        int qhi;
        int r;
        int t;
        int k;
        for (int p = 0; p < phases; p++)
        begin
            idle_en = (p < phases - 4) ? ($urandom_range(0, 4) != 0) : 1'b0;
            r = $urandom_range(0, 9);
            if (r == 0)
                n = $urandom_range(0, 1);
            else if (r == 1)
                n = $urandom_range(17, 31);
            else
                n = $urandom_range(2, 16);
            eff = (n > KEY_SLOTS) ? KEY_SLOTS : n;
            // frame span: full range or a narrow window
            shape = $urandom_range(0, 3);
            if (shape == 0)
            begin
                lo = -32768;
                hi = 32767;
            end
            else
            begin
                ctr  = int'($urandom_range(0, 65535)) - 32768;
                span = int'($urandom_range(1, 200)) * (eff + 1);
                lo   = ctr - span / 2;
                if (lo < -32768)
                    lo = -32768;
                hi = lo + span;
                if (hi > 32767)
                    hi = 32767;
            end
            for (int s = 0; s < eff; s++)
                vals[s] = lo + int'($urandom_range(0, hi - lo));
            // shape 2 leaves the table unsorted
            if (shape != 2)
                for (int s = 1; s < eff; s++)
                begin
                    t = vals[s];
                    k = s - 1;
                    while (k >= 0 && vals[k] > t)
                    begin
                        vals[k+1] = vals[k];
                        k--;
                    end
                    vals[k+1] = t;
                end
            for (int s = 0; s < eff; s++)
                write_key(4'(s), vals[s], random_alpha());
            // keys past the count must not matter
            if (eff < KEY_SLOTS)
                repeat ($urandom_range(0, 2))
                    write_key(4'($urandom_range(eff, KEY_SLOTS - 1)),
                              int'($urandom_range(0, 65535)) - 32768, random_alpha());
            set_key_count(5'(n));
            qlo = (lo - 3 < -32768) ? -32768 : lo - 3;
            qhi = (hi + 3 > 32767) ? 32767 : hi + 3;
            for (int q = 0; q < 30; q++)
            begin
                if (q == 15 && (p == 3 || $urandom_range(0, 7) == 0))
                    drain_results();
                r = $urandom_range(0, 19);
                if (r < 2)
                    query_at(int'($urandom_range(0, 65535)) - 32768);
                else if (r < 5 && eff > 0)
                    query_at(int'(kf_frame[$urandom_range(0, eff - 1)]));
                else if (r == 5)
                    write_key(4'($urandom_range(0, 15)), qlo + int'($urandom_range(0, qhi - qlo)),
                              random_alpha());
                else
                    query_at(qlo + int'($urandom_range(0, qhi - qlo)));
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        item_bus.valid        = 1'b0;
        item_bus.op           = OP_WRITE;
        item_bus.slot         = '0;
        item_bus.frame_number = '0;
        item_bus.key_alpha    = '0;
        idle_en               = 1'b1;
        key_count             = '0;
        for (int s = 0; s < KEY_SLOTS; s++)
        begin
            kf_frame[s] = RESET_ENTRY.frame;
            kf_alpha[s] = RESET_ENTRY.alpha;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_table();
        test_directed_keys();
        test_random_tables(25);

        drain_results();
        repeat (60) @(posedge clk);
        $display("Ran %0d keyframe writes and %0d queries (%0d interpolated) over %0d key counts",
                 write_beats, query_beats, lerp_queries, count_settings);
        $display("Checked %0d alpha beats with %0d mismatches", result_beats, error_count);
        if (error_count == 0)
            $display("keyframe_visibility_interpolator_unit test passed");
        else
            $display("keyframe_visibility_interpolator_unit test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/kvi_pkg.sv
rtl/kvi_item_if.sv
rtl/kvi_result_if.sv
rtl/keyframe_visibility_interpolator_unit.sv
tb/tb_top.sv
